// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the RTL. They compile to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// plain clocked check, off while reset is asserted
`define GCR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gcr assertion failed");

// trigger in one cycle, consequence in the next
`define GCR_ASSERT_NEXT(lbl, clk, rst_n, trig, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("gcr assertion failed");

`else

`define GCR_ASSERT(lbl, clk, rst_n, prop)
`define GCR_ASSERT_NEXT(lbl, clk, rst_n, trig, prop)

`endif

`endif

// File: sv/gcr_pkg.sv
// ----------------------------------------------------------------------------
// Game-pad responder package
// Control word format, microprogram ROM and command dispatch table.
// ----------------------------------------------------------------------------
package gcr_pkg;

    localparam int unsigned PC_W      = 7;
    localparam logic [PC_W-1:0] ROM_DEPTH = 7'd90;
    localparam logic [PC_W-1:0] PC_INC    = 7'd1;

    typedef enum logic [2:0] {
        OP_HOST    = 3'd0,
        OP_PRESS   = 3'd1,
        OP_RELEASE = 3'd2,
        OP_ANALOG  = 3'd3,
        OP_AXIS    = 3'd4
    } t_op;

    localparam logic [1:0] MODE_DIGITAL  = 2'd0;
    localparam logic [1:0] MODE_ANALOG   = 2'd1;
    localparam logic [1:0] MODE_PRESSURE = 2'd2;

    // low nibble of host commands 0x40..0x4F
    localparam logic [3:0] CMD_STATUS   = 4'h0;
    localparam logic [3:0] CMD_MASK_Q   = 4'h1;
    localparam logic [3:0] CMD_POLL     = 4'h2;
    localparam logic [3:0] CMD_CONFIG   = 4'h3;
    localparam logic [3:0] CMD_MODE_SEL = 4'h4;
    localparam logic [3:0] CMD_MODEL    = 4'h5;
    localparam logic [3:0] CMD_ACT_Q    = 4'h6;
    localparam logic [3:0] CMD_COMB_Q   = 4'h7;
    localparam logic [3:0] CMD_MODE_Q   = 4'hC;
    localparam logic [3:0] CMD_MOTOR    = 4'hD;
    localparam logic [3:0] CMD_NATIVE   = 4'hF;
    localparam logic [3:0] CMD_GROUP    = 4'h4;

    // second argument of the mode select that locks the mode
    localparam logic [7:0] LOCK_KEY    = 8'd3;

    localparam logic [7:0] AXIS_CENTER = 8'h7f;

    typedef enum logic [3:0] {
        SRC_LIT,
        SRC_MASK0,
        SRC_MASK1,
        SRC_RUM0,
        SRC_RUM1,
        SRC_BTN_LO,
        SRC_BTN_HI,
        SRC_AX0,
        SRC_AX1,
        SRC_AX2,
        SRC_AX3,
        SRC_ID_POLL,
        SRC_ID_CFG,
        SRC_MODE_FLAG,
        SRC_MOTOR_MAP
    } t_src;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_DIGITAL,
        COND_NO_PRES,
        COND_IN_CFG,
        COND_ARG_ZERO
    } t_cond;

    // ACT_END: this byte is last when cond holds, else fall through
    typedef enum logic [1:0] {
        ACT_NEXT,
        ACT_JUMP,
        ACT_END,
        ACT_RET
    } t_act;

    typedef struct packed {
        logic            emit;
        t_src            src;
        logic [7:0]      lit;
        t_act            act;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic            known;
        logic [PC_W-1:0] start;
        logic [PC_W-1:0] ret;
    } t_dispatch;

    // microprogram entry points
    localparam logic [PC_W-1:0] A_HDR     = 7'd0;
    localparam logic [PC_W-1:0] A_ZERO    = 7'd3;
    localparam logic [PC_W-1:0] A_P40     = 7'd9;
    localparam logic [PC_W-1:0] A_P41     = 7'd15;
    localparam logic [PC_W-1:0] A_C42     = 7'd22;
    localparam logic [PC_W-1:0] A_BUTTONS = 7'd25;
    localparam logic [PC_W-1:0] A_C43     = 7'd43;
    localparam logic [PC_W-1:0] A_P45     = 7'd47;
    localparam logic [PC_W-1:0] A_P46     = 7'd53;
    localparam logic [PC_W-1:0] A_P46_Z   = 7'd60;
    localparam logic [PC_W-1:0] A_P47     = 7'd66;
    localparam logic [PC_W-1:0] A_P4C     = 7'd72;
    localparam logic [PC_W-1:0] A_P4D     = 7'd78;
    localparam logic [PC_W-1:0] A_P4F     = 7'd84;

    function automatic t_uword lit_word(logic [7:0] v, t_act a, t_cond c,
                                        logic [PC_W-1:0] t);
        t_uword w;
        w.emit   = 1'b1;
        w.src    = SRC_LIT;
        w.lit    = v;
        w.act    = a;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    function automatic t_uword src_word(t_src s, t_act a, t_cond c,
                                        logic [PC_W-1:0] t);
        t_uword w;
        w.emit   = 1'b1;
        w.src    = s;
        w.lit    = 8'h00;
        w.act    = a;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    function automatic t_uword lit_next(logic [7:0] v);
        return lit_word(v, ACT_NEXT, COND_ALWAYS, A_HDR);
    endfunction

    function automatic t_uword lit_end(logic [7:0] v);
        return lit_word(v, ACT_END, COND_ALWAYS, A_HDR);
    endfunction

    function automatic t_uword src_next(t_src s);
        return src_word(s, ACT_NEXT, COND_ALWAYS, A_HDR);
    endfunction

    // no byte, jump when cond holds
    function automatic t_uword branch(t_cond c, logic [PC_W-1:0] t);
        t_uword w;
        w        = lit_word(8'h00, ACT_JUMP, c, t);
        w.emit   = 1'b0;
        return w;
    endfunction

    function automatic t_uword rom_word(logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            // config header FF F3 5A, then return to the payload block
            7'd0:  w = lit_next(8'hff);
            7'd1:  w = lit_next(8'hf3);
            7'd2:  w = lit_word(8'h5a, ACT_RET, COND_ALWAYS, A_HDR);
            // all-zero payload
            7'd3:  w = lit_next(8'h00);
            7'd4:  w = lit_next(8'h00);
            7'd5:  w = lit_next(8'h00);
            7'd6:  w = lit_next(8'h00);
            7'd7:  w = lit_next(8'h00);
            7'd8:  w = lit_end(8'h00);
            // 0x40
            7'd9:  w = lit_next(8'h00);
            7'd10: w = lit_next(8'h00);
            7'd11: w = lit_next(8'h02);
            7'd12: w = lit_next(8'h00);
            7'd13: w = lit_next(8'h00);
            7'd14: w = lit_end(8'h5a);
            // 0x41
            7'd15: w = branch(COND_DIGITAL, A_ZERO);
            7'd16: w = src_next(SRC_MASK0);
            7'd17: w = src_next(SRC_MASK1);
            7'd18: w = lit_next(8'h03);
            7'd19: w = lit_next(8'h00);
            7'd20: w = lit_next(8'h00);
            7'd21: w = lit_end(8'h5a);
            // 0x42 poll, shared tail with 0x43 from the button bytes on
            7'd22: w = lit_next(8'hff);
            7'd23: w = src_next(SRC_ID_POLL);
            7'd24: w = lit_next(8'h5a);
            7'd25: w = src_next(SRC_BTN_LO);
            7'd26: w = src_word(SRC_BTN_HI, ACT_END, COND_DIGITAL, A_HDR);
            7'd27: w = src_next(SRC_AX1);
            7'd28: w = src_next(SRC_AX0);
            7'd29: w = src_next(SRC_AX3);
            7'd30: w = src_word(SRC_AX2, ACT_END, COND_NO_PRES, A_HDR);
            7'd31: w = lit_next(8'hff);
            7'd32: w = lit_next(8'hff);
            7'd33: w = lit_next(8'hff);
            7'd34: w = lit_next(8'hff);
            7'd35: w = lit_next(8'hff);
            7'd36: w = lit_next(8'hff);
            7'd37: w = lit_next(8'hff);
            7'd38: w = lit_next(8'hff);
            7'd39: w = lit_next(8'hff);
            7'd40: w = lit_next(8'hff);
            7'd41: w = lit_next(8'hff);
            7'd42: w = lit_end(8'hff);
            // 0x43
            7'd43: w = branch(COND_IN_CFG, A_HDR);
            7'd44: w = lit_next(8'hff);
            7'd45: w = src_next(SRC_ID_CFG);
            7'd46: w = lit_word(8'h5a, ACT_JUMP, COND_ALWAYS, A_BUTTONS);
            // 0x45
            7'd47: w = lit_next(8'h03);
            7'd48: w = lit_next(8'h02);
            7'd49: w = src_next(SRC_MODE_FLAG);
            7'd50: w = lit_next(8'h02);
            7'd51: w = lit_next(8'h01);
            7'd52: w = lit_end(8'h00);
            // 0x46
            7'd53: w = branch(COND_ARG_ZERO, A_P46_Z);
            7'd54: w = lit_next(8'h00);
            7'd55: w = lit_next(8'h00);
            7'd56: w = lit_next(8'h01);
            7'd57: w = lit_next(8'h01);
            7'd58: w = lit_next(8'h01);
            7'd59: w = lit_end(8'h14);
            7'd60: w = lit_next(8'h00);
            7'd61: w = lit_next(8'h00);
            7'd62: w = lit_next(8'h01);
            7'd63: w = lit_next(8'h02);
            7'd64: w = lit_next(8'h00);
            7'd65: w = lit_end(8'h0a);
            // 0x47
            7'd66: w = lit_next(8'h00);
            7'd67: w = lit_next(8'h00);
            7'd68: w = lit_next(8'h02);
            7'd69: w = lit_next(8'h00);
            7'd70: w = lit_next(8'h01);
            7'd71: w = lit_end(8'h00);
            // 0x4C
            7'd72: w = lit_next(8'h00);
            7'd73: w = lit_next(8'h00);
            7'd74: w = lit_next(8'h00);
            7'd75: w = src_next(SRC_MOTOR_MAP);
            7'd76: w = lit_next(8'h00);
            7'd77: w = lit_end(8'h00);
            // 0x4D
            7'd78: w = src_next(SRC_RUM0);
            7'd79: w = src_next(SRC_RUM1);
            7'd80: w = lit_next(8'hff);
            7'd81: w = lit_next(8'hff);
            7'd82: w = lit_next(8'hff);
            7'd83: w = lit_end(8'hff);
            // 0x4F
            7'd84: w = lit_next(8'h00);
            7'd85: w = lit_next(8'h00);
            7'd86: w = lit_next(8'h00);
            7'd87: w = lit_next(8'h00);
            7'd88: w = lit_next(8'h00);
            7'd89: w = lit_end(8'h5a);
            default: w = lit_end(8'h00);
        endcase
        return w;
    endfunction

    function automatic t_dispatch dispatch(logic [7:0] cmd);
        t_dispatch d;
        d.known = (cmd[7:4] == CMD_GROUP);
        d.start = A_HDR;
        d.ret   = A_ZERO;
        case (cmd[3:0])
            CMD_STATUS:   d.ret   = A_P40;
            CMD_MASK_Q:   d.ret   = A_P41;
            CMD_POLL:     d.start = A_C42;
            CMD_CONFIG:   d.start = A_C43;
            CMD_MODE_SEL: d.ret   = A_ZERO;
            CMD_MODEL:    d.ret   = A_P45;
            CMD_ACT_Q:    d.ret   = A_P46;
            CMD_COMB_Q:   d.ret   = A_P47;
            CMD_MODE_Q:   d.ret   = A_P4C;
            CMD_MOTOR:    d.ret   = A_P4D;
            CMD_NATIVE:   d.ret   = A_P4F;
            default:      d.known = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// File: sv/gamepad_command_responder.sv
// ----------------------------------------------------------------------------
// Game-pad command responder
// Serial pad slave: a microprogram sequencer emits reply frames for host
// commands; local events update buttons, sticks and the analog mode.
//
//   channel   direction  handshake                 payload
//   request   in         i_in_valid / o_in_ready   i_op ... i_axis_level
//   reply     out        o_out_valid / i_out_ready o_reply_byte, o_reply_last
//
// One ROM step per cycle unless the output register stalls; each emitting step
// puts one byte in the output register. The branch steps of 0x41, 0x43 and
// 0x46 emit no byte. Replies run 5 to 21 bytes. Local events and unknown
// commands start no reply. A stalled output register stalls the sequencer.
// Command state changes with its last byte.
// Synchronous active-low reset restores the pad to digital mode, centered.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gamepad_command_responder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_command_code,
    input  logic [7:0]  i_arg_first,
    input  logic [7:0]  i_arg_second,
    input  logic [7:0]  i_arg_third,
    input  logic [15:0] i_button_bits,
    input  logic [1:0]  i_axis_select,
    input  logic [7:0]  i_axis_level,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_reply_byte,
    output logic        o_reply_last
);

    // sequencer
    logic                      r_busy;
    logic [gcr_pkg::PC_W-1:0]  r_pc;
    logic [gcr_pkg::PC_W-1:0]  r_ret;
    logic [3:0]                r_cmd;
    logic [7:0]                r_a1;
    logic [7:0]                r_a2;
    logic [7:0]                r_a3;

    // pad state
    logic [1:0]  r_pad_mode;
    logic        r_mode_locked;
    logic [7:0]  r_in_config;
    logic [7:0]  r_mask [2];
    logic [7:0]  r_rumble [2];
    logic [15:0] r_buttons;
    logic [7:0]  r_axes [4];

    // output register
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    gcr_pkg::t_uword          w;
    gcr_pkg::t_dispatch       disp;
    logic                     in_acc;
    logic                     out_free;
    logic                     step;
    logic                     cond_ok;
    logic                     is_last;
    logic [7:0]               byte_sel;
    logic [gcr_pkg::PC_W-1:0] n_pc;

    assign o_in_ready   = !r_busy;
    assign in_acc       = i_in_valid && !r_busy;
    assign o_out_valid  = r_out_valid;
    assign o_reply_byte = r_out_byte;
    assign o_reply_last = r_out_last;

    assign w        = gcr_pkg::rom_word(r_pc);
    assign disp     = gcr_pkg::dispatch(i_command_code);
    assign out_free = !r_out_valid || i_out_ready;
    assign step     = r_busy && (!w.emit || out_free);

    always_comb begin
        case (w.cond)
            gcr_pkg::COND_ALWAYS:   cond_ok = 1'b1;
            gcr_pkg::COND_DIGITAL:  cond_ok = (r_pad_mode == gcr_pkg::MODE_DIGITAL);
            // the pressure tail only follows a poll in mode 2 (or 3)
            gcr_pkg::COND_NO_PRES:  cond_ok = !((r_cmd == gcr_pkg::CMD_POLL) && r_pad_mode[1]);
            gcr_pkg::COND_IN_CFG:   cond_ok = (r_in_config != 8'h00);
            gcr_pkg::COND_ARG_ZERO: cond_ok = (r_a1 == 8'h00);
            default:                cond_ok = 1'b0;
        endcase
    end

    assign is_last = w.emit && (w.act == gcr_pkg::ACT_END) && cond_ok;

    always_comb begin
        case (w.src)
            gcr_pkg::SRC_LIT:       byte_sel = w.lit;
            gcr_pkg::SRC_MASK0:     byte_sel = r_mask[0];
            gcr_pkg::SRC_MASK1:     byte_sel = r_mask[1];
            gcr_pkg::SRC_RUM0:      byte_sel = r_rumble[0];
            gcr_pkg::SRC_RUM1:      byte_sel = r_rumble[1];
            gcr_pkg::SRC_BTN_LO:    byte_sel = r_buttons[7:0];
            gcr_pkg::SRC_BTN_HI:    byte_sel = r_buttons[15:8];
            gcr_pkg::SRC_AX0:       byte_sel = r_axes[0];
            gcr_pkg::SRC_AX1:       byte_sel = r_axes[1];
            gcr_pkg::SRC_AX2:       byte_sel = r_axes[2];
            gcr_pkg::SRC_AX3:       byte_sel = r_axes[3];
            gcr_pkg::SRC_ID_POLL:   byte_sel = (r_pad_mode == gcr_pkg::MODE_DIGITAL) ? 8'h41 :
                                               (r_pad_mode == gcr_pkg::MODE_ANALOG)  ? 8'h73 :
                                                                                       8'h79;
            gcr_pkg::SRC_ID_CFG:    byte_sel = (r_pad_mode != gcr_pkg::MODE_DIGITAL) ? 8'h73
                                                                                     : 8'h41;
            gcr_pkg::SRC_MODE_FLAG: byte_sel = {7'd0, (r_pad_mode != gcr_pkg::MODE_DIGITAL)};
            gcr_pkg::SRC_MOTOR_MAP: byte_sel = (r_a1 != 8'h00) ? 8'h07 : 8'h04;
            default:                byte_sel = 8'h00;
        endcase
    end

    always_comb begin
        case (w.act)
            gcr_pkg::ACT_JUMP: n_pc = cond_ok ? w.target : r_pc + gcr_pkg::PC_INC;
            gcr_pkg::ACT_RET:  n_pc = r_ret;
            default:           n_pc = r_pc + gcr_pkg::PC_INC;
        endcase
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= gcr_pkg::A_HDR;
            r_ret  <= gcr_pkg::A_ZERO;
        end else if (in_acc) begin
            if ((i_op == gcr_pkg::OP_HOST) && disp.known) begin
                r_busy <= 1'b1;
                r_pc   <= disp.start;
                r_ret  <= disp.ret;
            end
        end else if (step) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else begin
                r_pc <= n_pc;
            end
        end
    end

    // latched request arguments
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= i_command_code[3:0];
            r_a1  <= i_arg_first;
            r_a2  <= i_arg_second;
            r_a3  <= i_arg_third;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && w.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && w.emit) begin
            r_out_byte <= byte_sel;
            r_out_last <= is_last;
        end
    end

    // pad state: local events on accept, command side effects on the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_mode    <= gcr_pkg::MODE_DIGITAL;
            r_mode_locked <= 1'b0;
            r_in_config   <= 8'h00;
            r_mask[0]     <= 8'hff;
            r_mask[1]     <= 8'hff;
            r_rumble[0]   <= 8'hff;
            r_rumble[1]   <= 8'hff;
            r_buttons     <= 16'hffff;
            r_axes[0]     <= gcr_pkg::AXIS_CENTER;
            r_axes[1]     <= gcr_pkg::AXIS_CENTER;
            r_axes[2]     <= gcr_pkg::AXIS_CENTER;
            r_axes[3]     <= gcr_pkg::AXIS_CENTER;
        end else if (in_acc) begin
            case (i_op)
                gcr_pkg::OP_PRESS:   r_buttons <= r_buttons & ~i_button_bits;
                gcr_pkg::OP_RELEASE: r_buttons <= r_buttons | i_button_bits;
                gcr_pkg::OP_ANALOG: begin
                    if (!r_mode_locked) begin
                        r_pad_mode <= (r_pad_mode != gcr_pkg::MODE_DIGITAL)
                                      ? gcr_pkg::MODE_DIGITAL : gcr_pkg::MODE_ANALOG;
                    end
                end
                gcr_pkg::OP_AXIS:    r_axes[i_axis_select] <= i_axis_level;
                default: ;
            endcase
        end else if (step && is_last) begin
            case (r_cmd)
                gcr_pkg::CMD_CONFIG: r_in_config <= r_a1;
                gcr_pkg::CMD_MODE_SEL: begin
                    if ((r_a1 < 8'd2) && !r_mode_locked) begin
                        r_pad_mode <= {1'b0, r_a1[0]};
                    end
                    r_mode_locked <= (r_a2 == gcr_pkg::LOCK_KEY);
                end
                gcr_pkg::CMD_MOTOR: begin
                    r_rumble[0] <= r_a1;
                    r_rumble[1] <= r_a2;
                end
                gcr_pkg::CMD_NATIVE: begin
                    r_mask[0] <= r_a1;
                    r_mask[1] <= r_a2;
                    if (!r_a3[0]) begin
                        r_pad_mode <= gcr_pkg::MODE_DIGITAL;
                    end else if (!r_a3[1]) begin
                        r_pad_mode <= gcr_pkg::MODE_ANALOG;
                    end else begin
                        r_pad_mode <= gcr_pkg::MODE_PRESSURE;
                    end
                end
                default: ;
            endcase
        end
    end

    `GCR_ASSERT(a_pc_in_rom, i_clk, i_rst_n, r_busy |-> (r_pc < gcr_pkg::ROM_DEPTH))
    `GCR_ASSERT_NEXT(a_last_ends_run, i_clk, i_rst_n, step && is_last, !r_busy && o_out_valid && o_reply_last)
    `GCR_ASSERT(a_out_from_run, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_busy))
    `GCR_ASSERT_NEXT(a_local_no_run, i_clk, i_rst_n, in_acc && (i_op != gcr_pkg::OP_HOST), !r_busy)

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Game-pad responder testbench
// Sends host commands and local pad events as requests. Every reply byte is
// checked in order against typed values or a software copy of the pad state.
// The sender runs in bursts with gaps, the receiver stalls on patterns of its
// own, and once the receiver holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;

    localparam int         RAND_REQS   = 95;
    localparam int         HOLD_CYCLES = 250;
    localparam int         IDLE_LIMIT  = 3000;
    localparam int         DRAIN_TAIL  = 48;
    localparam int         MAX_REPORTS = 10;

    localparam logic [2:0] OP_SPARE    = 3'd5;   // ops from here up are unused
    localparam logic [7:0] CODE_HOLE_LO = 8'h48;
    localparam logic [7:0] CODE_HOLE_HI = 8'h4e;
    localparam logic [7:0] CODE_OUTSIDE = 8'hff;
    localparam logic [7:0] ID_DIGITAL  = 8'h41;
    localparam logic [7:0] ID_ANALOG   = 8'h73;
    localparam logic [7:0] ID_PRESSURE = 8'h79;
    localparam logic [7:0] ID_CONFIG   = 8'hf3;
    localparam logic [7:0] FRAME_TAG   = 8'h5a;
    localparam logic [7:0] PAD_BYTE    = 8'hff;
    localparam int         PRESSURE_PAD = 12;

    localparam logic [3:0] KNOWN_NIB [11] = '{
        gcr_pkg::CMD_STATUS, gcr_pkg::CMD_MASK_Q, gcr_pkg::CMD_POLL,
        gcr_pkg::CMD_CONFIG, gcr_pkg::CMD_MODE_SEL, gcr_pkg::CMD_MODEL,
        gcr_pkg::CMD_ACT_Q, gcr_pkg::CMD_COMB_Q, gcr_pkg::CMD_MODE_Q,
        gcr_pkg::CMD_MOTOR, gcr_pkg::CMD_NATIVE
    };

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  cmd;
        logic [7:0]  arg1;
        logic [7:0]  arg2;
        logic [7:0]  arg3;
        logic [15:0] bits;
        logic [1:0]  axis;
        logic [7:0]  level;
    } t_req;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_reply;

    typedef struct {
        t_req        req;
        int          gold_len;   // -1: reply comes from the pad model
        logic [71:0] gold;       // right-justified, first byte most significant
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_op;
    logic [7:0]  i_command_code;
    logic [7:0]  i_arg_first;
    logic [7:0]  i_arg_second;
    logic [7:0]  i_arg_third;
    logic [15:0] i_button_bits;
    logic [1:0]  i_axis_select;
    logic [7:0]  i_axis_level;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_reply_byte;
    logic        o_reply_last;

    // pad model state
    logic [1:0]  pad_mode;
    logic        mode_lock;
    logic [7:0]  cfg_flag;
    logic [7:0]  mask_q [2];
    logic [7:0]  rumble_q [2];
    logic [15:0] btn_q;
    logic [7:0]  stick_q [4];

    logic [7:0]  frame [$];
    t_reply      reply_due [$];
    t_row        script [$];

    int          err_cnt;
    int          n_host;
    int          n_unknown;
    int          n_event;
    int          n_spare;
    int          n_bytes;
    int          n_squeeze;
    int          burst_left;
    logic [2:0]  modes_polled;
    bit          squeeze_req;

    gamepad_command_responder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_command_code (i_command_code),
        .i_arg_first    (i_arg_first),
        .i_arg_second   (i_arg_second),
        .i_arg_third    (i_arg_third),
        .i_button_bits  (i_button_bits),
        .i_axis_select  (i_axis_select),
        .i_axis_level   (i_axis_level),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_reply_byte   (o_reply_byte),
        .o_reply_last   (o_reply_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit cmd_known(input logic [7:0] c);
        foreach (KNOWN_NIB[i]) begin
            if (c == {gcr_pkg::CMD_GROUP, KNOWN_NIB[i]}) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit is_ignored(input t_req r);
        return (r.op > gcr_pkg::OP_AXIS) || (r.op == gcr_pkg::OP_HOST && !cmd_known(r.cmd));
    endfunction

    function automatic void cfg_frame(input logic [7:0] b0, b1, b2, b3, b4, b5);
        frame.push_back(PAD_BYTE);
        frame.push_back(ID_CONFIG);
        frame.push_back(FRAME_TAG);
        frame.push_back(b0);
        frame.push_back(b1);
        frame.push_back(b2);
        frame.push_back(b3);
        frame.push_back(b4);
        frame.push_back(b5);
    endfunction

    function automatic void cfg_zeros();
        cfg_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    endfunction

    function automatic void pad_bytes(input bit with_axes);
        frame.push_back(btn_q[7:0]);
        frame.push_back(btn_q[15:8]);
        if (with_axes) begin
            frame.push_back(stick_q[1]);
            frame.push_back(stick_q[0]);
            frame.push_back(stick_q[3]);
            frame.push_back(stick_q[2]);
        end
    endfunction

    // Applies one request to the pad model and leaves its reply in frame.
    function automatic void pad_respond(input t_req r);
        frame.delete();
        case (r.op)
            gcr_pkg::OP_HOST: if (r.cmd[7:4] == gcr_pkg::CMD_GROUP) begin
                case (r.cmd[3:0])
                    gcr_pkg::CMD_STATUS:
                        cfg_frame(8'h00, 8'h00, 8'h02, 8'h00, 8'h00, FRAME_TAG);
                    gcr_pkg::CMD_MASK_Q: begin
                        if (pad_mode == gcr_pkg::MODE_DIGITAL) cfg_zeros();
                        else cfg_frame(mask_q[0], mask_q[1], 8'h03, 8'h00, 8'h00,
                                       FRAME_TAG);
                    end
                    gcr_pkg::CMD_POLL: begin
                        frame.push_back(PAD_BYTE);
                        frame.push_back(pad_mode == gcr_pkg::MODE_DIGITAL ? ID_DIGITAL :
                                        pad_mode == gcr_pkg::MODE_ANALOG  ? ID_ANALOG :
                                                                            ID_PRESSURE);
                        frame.push_back(FRAME_TAG);
                        pad_bytes(pad_mode != gcr_pkg::MODE_DIGITAL);
                        if (pad_mode >= gcr_pkg::MODE_PRESSURE) begin
                            repeat (PRESSURE_PAD) frame.push_back(PAD_BYTE);
                        end
                    end
                    gcr_pkg::CMD_CONFIG: begin
                        if (cfg_flag == 8'h00) begin
                            frame.push_back(PAD_BYTE);
                            frame.push_back(pad_mode != gcr_pkg::MODE_DIGITAL ? ID_ANALOG
                                                                              : ID_DIGITAL);
                            frame.push_back(FRAME_TAG);
                            pad_bytes(pad_mode != gcr_pkg::MODE_DIGITAL);
                        end else begin
                            cfg_zeros();
                        end
                        cfg_flag = r.arg1;
                    end
                    gcr_pkg::CMD_MODE_SEL: begin
                        cfg_zeros();
                        if (r.arg1 < 8'd2 && !mode_lock)
                            pad_mode = (r.arg1 != 8'h00) ? gcr_pkg::MODE_ANALOG
                                                         : gcr_pkg::MODE_DIGITAL;
                        mode_lock = (r.arg2 == gcr_pkg::LOCK_KEY);
                    end
                    gcr_pkg::CMD_MODEL:
                        cfg_frame(8'h03, 8'h02, {7'b0, pad_mode != gcr_pkg::MODE_DIGITAL},
                                  8'h02, 8'h01, 8'h00);
                    gcr_pkg::CMD_ACT_Q: begin
                        if (r.arg1 == 8'h00)
                            cfg_frame(8'h00, 8'h00, 8'h01, 8'h02, 8'h00, 8'h0a);
                        else
                            cfg_frame(8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h14);
                    end
                    gcr_pkg::CMD_COMB_Q:
                        cfg_frame(8'h00, 8'h00, 8'h02, 8'h00, 8'h01, 8'h00);
                    gcr_pkg::CMD_MODE_Q:
                        cfg_frame(8'h00, 8'h00, 8'h00,
                                  r.arg1 != 8'h00 ? 8'h07 : 8'h04, 8'h00, 8'h00);
                    gcr_pkg::CMD_MOTOR: begin
                        cfg_frame(rumble_q[0], rumble_q[1], 8'hff, 8'hff, 8'hff, 8'hff);
                        rumble_q[0] = r.arg1;
                        rumble_q[1] = r.arg2;
                    end
                    gcr_pkg::CMD_NATIVE: begin
                        cfg_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, FRAME_TAG);
                        mask_q[0] = r.arg1;
                        mask_q[1] = r.arg2;
                        // native mode bits win over the lock
                        if (!r.arg3[0])      pad_mode = gcr_pkg::MODE_DIGITAL;
                        else if (!r.arg3[1]) pad_mode = gcr_pkg::MODE_ANALOG;
                        else                 pad_mode = gcr_pkg::MODE_PRESSURE;
                    end
                    default: ;
                endcase
            end
            gcr_pkg::OP_PRESS:   btn_q = btn_q & ~r.bits;
            gcr_pkg::OP_RELEASE: btn_q = btn_q | r.bits;
            gcr_pkg::OP_ANALOG: begin
                if (!mode_lock)
                    pad_mode = (pad_mode != gcr_pkg::MODE_DIGITAL) ? gcr_pkg::MODE_DIGITAL
                                                                   : gcr_pkg::MODE_ANALOG;
            end
            gcr_pkg::OP_AXIS:    stick_q[r.axis] = r.level;
            default: ;
        endcase
    endfunction

    function automatic void note_mismatch(input string what);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
    endfunction

    function automatic void host_row(input logic [7:0] c, a1, a2, a3,
                                     input int glen, input logic [71:0] g);
        t_row w;
        w.req      = '0;
        w.req.op   = gcr_pkg::OP_HOST;
        w.req.cmd  = c;
        w.req.arg1 = a1;
        w.req.arg2 = a2;
        w.req.arg3 = a3;
        w.gold_len = glen;
        w.gold     = g;
        script.push_back(w);
    endfunction

    // local events never reply
    function automatic void event_row(input logic [2:0] op, input logic [15:0] b,
                                      input logic [1:0] s, input logic [7:0] l);
        t_row w;
        w.req       = '0;
        w.req.op    = op;
        w.req.bits  = b;
        w.req.axis  = s;
        w.req.level = l;
        w.gold_len  = 0;
        w.gold      = '0;
        script.push_back(w);
    endfunction

    function automatic t_req rand_req();
        t_req r;
        int   pick;
        r.op    = 3'($urandom);
        r.cmd   = 8'($urandom);
        r.arg1  = 8'($urandom);
        r.arg2  = 8'($urandom);
        r.arg3  = 8'($urandom);
        r.bits  = 16'($urandom);
        r.axis  = 2'($urandom);
        r.level = 8'($urandom);
        pick    = $urandom_range(0, 99);
        if (pick < 52) begin
            r.op  = gcr_pkg::OP_HOST;
            r.cmd = {gcr_pkg::CMD_GROUP, KNOWN_NIB[$urandom_range(0, 10)]};
            // small first args reach the mode select and zero tests
            if ($urandom_range(0, 1) == 0) r.arg1 = 8'($urandom_range(0, 3));
            if ($urandom_range(0, 2) == 0) r.arg2 = gcr_pkg::LOCK_KEY;
        end else if (pick < 60) begin
            r.op = gcr_pkg::OP_HOST;
        end else if (pick < 72) begin
            r.op = gcr_pkg::OP_PRESS;
        end else if (pick < 84) begin
            r.op = gcr_pkg::OP_RELEASE;
        end else if (pick < 90) begin
            r.op = gcr_pkg::OP_ANALOG;
        end else if (pick < 98) begin
            r.op = gcr_pkg::OP_AXIS;
        end else begin
            r.op = 3'(int'(OP_SPARE) + $urandom_range(0, 2));
        end
        return r;
    endfunction

    // sender pacing: bursts of back-to-back requests, then a gap
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    task automatic offer(input t_req r, input int gold_len, input logic [71:0] gold);
        t_reply rb;
        i_op           <= r.op;
        i_command_code <= r.cmd;
        i_arg_first    <= r.arg1;
        i_arg_second   <= r.arg2;
        i_arg_third    <= r.arg3;
        i_button_bits  <= r.bits;
        i_axis_select  <= r.axis;
        i_axis_level   <= r.level;
        i_in_valid     <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);

        if (r.op == gcr_pkg::OP_HOST) begin
            if (cmd_known(r.cmd)) n_host++;
            else n_unknown++;
            if (r.cmd == {gcr_pkg::CMD_GROUP, gcr_pkg::CMD_POLL})
                modes_polled[pad_mode] = 1'b1;
        end else if (r.op <= gcr_pkg::OP_AXIS) begin
            n_event++;
        end else begin
            n_spare++;
        end

        pad_respond(r);
        if (gold_len < 0) begin
            foreach (frame[i]) begin
                rb.data = frame[i];
                rb.last = (i == frame.size() - 1);
                reply_due.push_back(rb);
            end
        end else begin
            for (int i = 0; i < gold_len; i++) begin
                rb.data = gold[8 * (gold_len - 1 - i) +: 8];
                rb.last = (i == gold_len - 1);
                reply_due.push_back(rb);
            end
        end
    endtask

    // reply checker
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_bytes++;
            if (reply_due.size() == 0) begin
                note_mismatch($sformatf("unexpected reply byte %02h last %0b",
                                        o_reply_byte, o_reply_last));
            end else begin
                want = reply_due.pop_front();
                if (o_reply_byte !== want.data)
                    note_mismatch($sformatf("reply_byte expected %02h got %02h",
                                            want.data, o_reply_byte));
                if (o_reply_last !== want.last)
                    note_mismatch($sformatf("reply_last expected %0b got %0b (byte %02h)",
                                            want.last, o_reply_last, want.data));
            end
        end
    end

    // receiver: stall patterns in spans, plus one long hold-off on request
    initial begin
        int style;
        int span;
        int tick;
        bit rdy;
        tick = 0;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                n_squeeze++;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(8, 64);
                repeat (span) begin
                    case (style)
                        0:       rdy = 1'b1;
                        1:       rdy = 1'($urandom_range(0, 1));
                        2:       rdy = ($urandom_range(0, 3) != 0);
                        default: rdy = (tick % 3 == 0);
                    endcase
                    i_out_ready <= rdy;
                    @(posedge i_clk);
                    tick++;
                end
            end
        end
    end

    // watchdog on cycles where neither channel moves
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle = 0;
            else idle++;
        end
        $display("watchdog: nothing moved for %0d cycles, %0d reply bytes outstanding",
                 IDLE_LIMIT, reply_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_req r;
        int   n_rand;
        bit   squeeze_sent;
        n_rand       = 0;
        squeeze_sent = 1'b0;
        err_cnt      = 0;
        n_host       = 0;
        n_unknown    = 0;
        n_event      = 0;
        n_spare      = 0;
        n_bytes      = 0;
        n_squeeze    = 0;
        burst_left   = 0;
        modes_polled = '0;
        squeeze_req  = 1'b0;

        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_op           <= gcr_pkg::OP_HOST;
        i_command_code <= '0;
        i_arg_first    <= '0;
        i_arg_second   <= '0;
        i_arg_third    <= '0;
        i_button_bits  <= '0;
        i_axis_select  <= '0;
        i_axis_level   <= '0;

        pad_mode    = gcr_pkg::MODE_DIGITAL;
        mode_lock   = 1'b0;
        cfg_flag    = 8'h00;
        mask_q[0]   = 8'hff;
        mask_q[1]   = 8'hff;
        rumble_q[0] = 8'hff;
        rumble_q[1] = 8'hff;
        btn_q       = 16'hffff;
        foreach (stick_q[i]) stick_q[i] = gcr_pkg::AXIS_CENTER;

        // directed requests: typed replies from reset state, then model-checked
        host_row({gcr_pkg::CMD_GROUP, gcr_pkg::CMD_POLL},   8'h00, 8'h00, 8'h00, 5,
                 72'hff_41_5a_ff_ff);
        host_row({gcr_pkg::CMD_GROUP, gcr_pkg::CMD_STATUS}, 8'h00, 8'h00, 8'h00, 9,
                 72'hff_f3_5a_00_00_02_00_00_5a);
        host_row({gcr_pkg::CMD_GROUP, gcr_pkg::CMD_MASK_Q}, 8'h00, 8'h00, 8'h00, 9,
                 72'hff_f3_5a_00_00_00_00_00_00);
        host_row({gcr_pkg::CMD_GROUP, gcr_pkg::CMD_MODEL},  8'h00, 8'h00, 8'h00, 9,
                 72'hff_f3_5a_03_02_00_02_01_00);
        host_row({gcr_pkg::CMD_GROUP, gcr_pkg::CMD_ACT_Q},  8'h00, 8'h00, 8'h00, 9,
                 72'hff_f3_5a_00_00_01_02_00_0a);
        host_row({gcr_pkg::CMD_GROUP, gcr_pkg::CMD_ACT_Q},  8'hff, 8'hff, 8'hff, 9,
                 72'hff_f3_5a_00_00_01_01_01_14);
        host_row({gcr_pkg::CMD_GROUP, gcr_pkg::CMD_COMB_Q}, 8'h00, 8'h00, 8'h00, 9,
                 72'hff_f3_5a_00_00_02_00_01_00);
        host_row({gcr_pkg::CMD_GROUP, gcr_pkg::CMD_MODE_Q}, 8'hff, 8'h00, 8'h00, 9,
                 72'hff_f3_5a_00_00_00_07_00_00);
        host_row({gcr_pkg::CMD_GROUP, gcr_pkg::CMD_MOTOR},  8'h00, 8'hff, 8'h00, 9,
                 72'hff_f3_5a_ff_ff_ff_ff_ff_ff);
        host_row(CODE_HOLE_LO, 8'hff, 8'hff, 8'hff, 0, '0);
        host_row(CODE_HOLE_HI, 8'hff, 8'hff, 8'hff, 0, '0);
        host_row(CODE_OUTSIDE, 8'hff, 8'hff, 8'hff, 0, '0);
        event_row(gcr_pkg::OP_PRESS,   16'hffff, 2'd0, 8'h00);
        event_row(gcr_pkg::OP_RELEASE, 16'h5a5a, 2'd0, 8'h00);
        event_row(gcr_pkg::OP_AXIS,    16'h0000, 2'd3, 8'hff);
        event_row(gcr_pkg::OP_ANALOG,  16'h0000, 2'd0, 8'h00);
        host_row({gcr_pkg::CMD_GROUP, gcr_pkg::CMD_POLL},   8'h00, 8'h00, 8'h00, -1, '0);
        host_row({gcr_pkg::CMD_GROUP, gcr_pkg::CMD_CONFIG}, 8'hff, 8'h00, 8'h00, -1, '0);
        host_row({gcr_pkg::CMD_GROUP, gcr_pkg::CMD_CONFIG}, 8'h00, 8'h00, 8'h00, -1, '0);
        // back to digital and lock, then the analog button must do nothing
        host_row({gcr_pkg::CMD_GROUP, gcr_pkg::CMD_MODE_SEL}, 8'h00, gcr_pkg::LOCK_KEY,
                 8'h00, -1, '0);
        event_row(gcr_pkg::OP_ANALOG, 16'h0000, 2'd0, 8'h00);
        host_row({gcr_pkg::CMD_GROUP, gcr_pkg::CMD_NATIVE}, 8'hff, 8'h00, 8'h03, -1, '0);
        host_row({gcr_pkg::CMD_GROUP, gcr_pkg::CMD_POLL},   8'h00, 8'h00, 8'h00, -1, '0);
        host_row({gcr_pkg::CMD_GROUP, gcr_pkg::CMD_MASK_Q}, 8'h00, 8'h00, 8'h00, -1, '0);
        event_row(OP_SPARE, 16'hffff, 2'd3, 8'hff);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) begin
            pace();
            offer(script[k].req, script[k].gold_len, script[k].gold);
        end

        while (n_rand < RAND_REQS) begin
            r = rand_req();
            pace();
            offer(r, -1, '0);
            if (!is_ignored(r)) n_rand++;
            if (!squeeze_sent && n_rand >= RAND_REQS / 3) begin
                squeeze_req  = 1'b1;
                squeeze_sent = 1'b1;
            end
        end
        i_in_valid <= 1'b0;

        while (reply_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("covered %0d host commands, %0d unknown codes, %0d pad events, %0d spare ops",
                 n_host, n_unknown, n_event, n_spare);
        $display("%0d reply bytes checked, poll modes seen %b, %0d long hold-off(s), %0d errors",
                 n_bytes, modes_polled, n_squeeze, err_cnt);
        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
